// ----- src/priority_output_arbiter_top_macros.svh -----
// Assertion macros used by the arbiter checker.
`ifndef PRIORITY_OUTPUT_ARBITER_TOP_MACROS_SVH
`define PRIORITY_OUTPUT_ARBITER_TOP_MACROS_SVH

// Checked only while out of reset.
`define POA_ASSERT_RUN(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked on every edge, reset included.
`define POA_ASSERT_ALL(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- src/poa_pkg.sv -----
// Package: transaction types, codes and controller/datapath interface of the arbiter.
package poa_pkg;

  localparam int NUM_OUTPUTS_DEF = 16;

  // Operation codes
  localparam logic [2:0] OP_ON     = 3'd0;
  localparam logic [2:0] OP_OFF    = 3'd1;
  localparam logic [2:0] OP_TOGGLE = 3'd2;
  localparam logic [2:0] OP_PULSE  = 3'd3;
  localparam logic [2:0] OP_TICK   = 3'd4;
  localparam logic [2:0] OP_INIT   = 3'd5;

  // Output modes
  localparam logic [1:0] MODE_OFF     = 2'd0;
  localparam logic [1:0] MODE_ON      = 2'd1;
  localparam logic [1:0] MODE_PULSING = 2'd2;
  localparam logic [1:0] MODE_FAULT   = 2'd3;

  // Status codes
  localparam logic [1:0] ST_OK         = 2'd0;
  localparam logic [1:0] ST_BAD_OUTPUT = 2'd1;
  localparam logic [1:0] ST_BAD_OP     = 2'd2;
  localparam logic [1:0] ST_WRITE_FAIL = 2'd3;

  // ms -> s: floor(x / 1000) == (x * ceil(2^38 / 1000)) >> 38 for every 32-bit x
  localparam int MS_PER_S  = 1000;
  localparam int DIV_SHIFT = 38;
  localparam int MAGIC_W   = 29;
  localparam logic [MAGIC_W-1:0] DIV_MAGIC =
    MAGIC_W'(((64'd1 << DIV_SHIFT) + 64'(MS_PER_S) - 64'd1) / 64'(MS_PER_S));
  localparam int PROD_W    = 32 + MAGIC_W;

  typedef struct packed {
    logic [2:0]  operation;
    logic [7:0]  output_number;
    logic [7:0]  request_priority;
    logic [15:0] owner_id;
    logic [31:0] pulse_ms;
    logic [31:0] now_time;
    logic        write_ok;
  } in_item_t;

  typedef struct packed {
    logic [4:0] drive_output;
    logic       drive_level;
    logic       drive_valid;
    logic [1:0] result_mode;
    logic [1:0] status;
    logic       last_result;
  } out_item_t;

  typedef struct packed {
    logic load_in;
    logic clr_idx;
    logic scan_step;
    logic skip_bit;
    logic emit_bit;
    logic emit_empty;
    logic commit_single;
    logic init_step;
  } poa_cmd_t;

  typedef struct packed {
    logic is_tick;
    logic is_init;
    logic out_free;
    logic idx_last;
    logic mask_zero;
    logic bit_set;
    logic last_bit;
  } poa_sts_t;

endpackage

// ----- src/poa_ctrl.sv -----
// Controller: sequences decode, single updates, tick scan/emit and init walk.
module poa_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  poa_pkg::poa_sts_t sts,
  output poa_pkg::poa_cmd_t cmd
);
  import poa_pkg::*;

  typedef enum logic [5:0] {
    S_IDLE   = 6'b000001,
    S_DECODE = 6'b000010,
    S_CALC   = 6'b000100,
    S_SCAN   = 6'b001000,
    S_EMIT   = 6'b010000,
    S_INIT   = 6'b100000
  } state_t;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_stall = (state_r != S_IDLE);

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load_in = 1'b1;
          state_nxt   = S_DECODE;
        end
      end
      S_DECODE: begin
        cmd.clr_idx = 1'b1;
        if (sts.is_tick) begin
          state_nxt = S_SCAN;
        end else if (sts.is_init) begin
          state_nxt = S_INIT;
        end else begin
          state_nxt = S_CALC;
        end
      end
      S_CALC: begin
        if (sts.out_free) begin
          cmd.commit_single = 1'b1;
          state_nxt         = S_IDLE;
        end
      end
      S_SCAN: begin
        cmd.scan_step = 1'b1;
        if (sts.idx_last) begin
          cmd.clr_idx = 1'b1;
          state_nxt   = S_EMIT;
        end
      end
      S_EMIT: begin
        if (sts.mask_zero) begin
          // nothing expired: one empty result
          if (sts.out_free) begin
            cmd.emit_empty = 1'b1;
            state_nxt      = S_IDLE;
          end
        end else if (!sts.bit_set) begin
          cmd.skip_bit = 1'b1;
        end else if (sts.out_free) begin
          cmd.emit_bit = 1'b1;
          if (sts.last_bit) begin
            state_nxt = S_IDLE;
          end
        end
      end
      S_INIT: begin
        if (sts.out_free) begin
          cmd.init_step = 1'b1;
          if (sts.idx_last) begin
            state_nxt = S_IDLE;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule

// ----- src/poa_dp.sv -----
// Datapath: per-output state, arbitration, pulse deadline and result register.
module poa_dp #(
  parameter int NUM_OUTPUTS = poa_pkg::NUM_OUTPUTS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  poa_pkg::in_item_t  in_data,
  input  logic               cfg_we,
  input  logic [15:0]        cfg_wdata,
  input  poa_pkg::poa_cmd_t  cmd,
  output poa_pkg::poa_sts_t  sts,
  output logic               out_valid,
  input  logic               out_stall,
  output poa_pkg::out_item_t out_data
);
  import poa_pkg::*;

  localparam int IDX_W = (NUM_OUTPUTS > 1) ? $clog2(NUM_OUTPUTS) : 1;

  in_item_t               in_r;
  logic [15:0]            mask_cfg_r;
  logic [PROD_W-1:0]      prod_r;
  logic [IDX_W-1:0]       idx_r;
  logic [NUM_OUTPUTS-1:0] exp_r;
  logic                   out_valid_r;
  out_item_t              out_r;

  logic [1:0]  mode_r  [NUM_OUTPUTS];
  logic [7:0]  opri_r  [NUM_OUTPUTS];
  logic [15:0] orule_r [NUM_OUTPUTS];
  logic [31:0] dline_r [NUM_OUTPUTS];

  // single-request arbitration
  logic [7:0]       num_m1;
  logic [IDX_W-1:0] sidx;
  logic             num_ok;
  logic [1:0]       cur_mode;
  logic             lvl;
  logic             skip;
  logic             drove;
  logic [1:0]       new_mode;
  logic [1:0]       st;
  logic             set_dline;
  logic [31:0]      dline_nxt;
  out_item_t        single_res;

  // tick / init
  logic                   expire;
  logic [NUM_OUTPUTS-1:0] idx_bit;
  logic [4:0]             idx_num;
  logic                   init_lvl;

  logic      out_load;
  out_item_t out_nxt;
  logic      step_idx;

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      in_r <= in_data;
    end
    prod_r <= PROD_W'(in_r.pulse_ms) * PROD_W'(DIV_MAGIC);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mask_cfg_r <= '0;
    end else if (cfg_we) begin
      mask_cfg_r <= cfg_wdata;
    end
  end

  assign num_m1   = in_r.output_number - 8'd1;
  assign sidx     = num_m1[IDX_W-1:0];
  assign num_ok   = (in_r.output_number != 8'd0) &&
                    (in_r.output_number <= 8'(NUM_OUTPUTS));
  assign cur_mode = mode_r[sidx];

  always_comb begin
    case (in_r.operation)
      OP_OFF:    lvl = 1'b0;
      OP_TOGGLE: lvl = (cur_mode != MODE_ON);
      default:   lvl = 1'b1;
    endcase
    if (lvl) begin
      skip = (in_r.request_priority < opri_r[sidx]) || (cur_mode == MODE_ON);
    end else begin
      skip = ((orule_r[sidx] != in_r.owner_id) &&
              (in_r.request_priority < opri_r[sidx])) || (cur_mode == MODE_OFF);
    end
    drove     = !skip;
    st        = (drove && !in_r.write_ok) ? ST_WRITE_FAIL : ST_OK;
    new_mode  = cur_mode;
    if (drove) begin
      new_mode = !in_r.write_ok ? MODE_FAULT : (lvl ? MODE_ON : MODE_OFF);
    end
    // pulse arms even when arbitration skipped the write
    set_dline = (in_r.operation == OP_PULSE) && (st == ST_OK);
    if (set_dline) begin
      new_mode = MODE_PULSING;
    end
    dline_nxt = in_r.now_time + 32'(prod_r[PROD_W-1:DIV_SHIFT]);

    single_res             = '0;
    single_res.last_result = 1'b1;
    if (in_r.operation > OP_INIT) begin
      single_res.status = ST_BAD_OP;
    end else if (!num_ok) begin
      single_res.status = ST_BAD_OUTPUT;
    end else begin
      single_res.drive_output = drove ? 5'(in_r.output_number) : 5'd0;
      single_res.drive_level  = drove & lvl;
      single_res.drive_valid  = drove;
      single_res.result_mode  = new_mode;
      single_res.status       = st;
    end
  end

  assign expire   = (mode_r[idx_r] == MODE_PULSING) && (in_r.now_time >= dline_r[idx_r]);
  assign idx_bit  = NUM_OUTPUTS'(1) << idx_r;
  assign idx_num  = 5'(idx_r) + 5'd1;
  assign init_lvl = mask_cfg_r[idx_r];

  // state table
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_OUTPUTS; i++) begin
        mode_r[i]  <= MODE_OFF;
        opri_r[i]  <= '0;
        orule_r[i] <= '0;
        dline_r[i] <= '0;
      end
    end else if (cmd.commit_single) begin
      if (num_ok && (in_r.operation <= OP_PULSE)) begin
        mode_r[sidx] <= new_mode;
        if (drove) begin
          opri_r[sidx]  <= in_r.request_priority;
          orule_r[sidx] <= in_r.owner_id;
        end
        if (set_dline) begin
          dline_r[sidx] <= dline_nxt;
        end
      end
    end else if (cmd.scan_step) begin
      if (expire) begin
        mode_r[idx_r] <= MODE_OFF;
        opri_r[idx_r] <= '0;
      end
    end else if (cmd.init_step) begin
      mode_r[idx_r]  <= init_lvl ? MODE_ON : MODE_OFF;
      opri_r[idx_r]  <= '0;
      orule_r[idx_r] <= '0;
      dline_r[idx_r] <= '0;
    end
  end

  // walk index and expiry set
  assign step_idx = cmd.scan_step | cmd.skip_bit | cmd.emit_bit | cmd.init_step;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r <= '0;
      exp_r <= '0;
    end else begin
      if (cmd.clr_idx) begin
        idx_r <= '0;
      end else if (step_idx) begin
        idx_r <= idx_r + IDX_W'(1);
      end
      if (cmd.load_in) begin
        exp_r <= '0;
      end else if (cmd.scan_step && expire) begin
        exp_r <= exp_r | idx_bit;
      end else if (cmd.emit_bit) begin
        exp_r <= exp_r & ~idx_bit;
      end
    end
  end

  // result register
  always_comb begin
    out_nxt             = '0;
    out_nxt.last_result = 1'b1;
    if (cmd.commit_single) begin
      out_nxt = single_res;
    end else if (cmd.emit_bit) begin
      out_nxt.drive_output = idx_num;
      out_nxt.drive_valid  = 1'b1;
      out_nxt.result_mode  = MODE_OFF;
      out_nxt.status       = ST_OK;
      out_nxt.last_result  = sts.last_bit;
    end else if (cmd.init_step) begin
      out_nxt.drive_output = idx_num;
      out_nxt.drive_level  = init_lvl;
      out_nxt.drive_valid  = 1'b1;
      out_nxt.result_mode  = init_lvl ? MODE_ON : MODE_OFF;
      out_nxt.status       = ST_OK;
      out_nxt.last_result  = sts.idx_last;
    end
  end

  assign out_load = cmd.commit_single | cmd.emit_bit | cmd.emit_empty | cmd.init_step;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_r <= out_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  always_comb begin
    sts           = '0;
    sts.is_tick   = (in_r.operation == OP_TICK);
    sts.is_init   = (in_r.operation == OP_INIT);
    sts.out_free  = !out_valid_r || !out_stall;
    sts.idx_last  = (idx_r == IDX_W'(NUM_OUTPUTS - 1));
    sts.mask_zero = (exp_r == '0);
    sts.bit_set   = |(exp_r & idx_bit);
    sts.last_bit  = ((exp_r & ~idx_bit) == '0);
  end

endmodule

// ----- src/priority_output_arbiter_top.sv -----
// Sequence: on/off/toggle/pulse and invalid requests are registered on acceptance,
//   decoded, and their result loaded once the output register is free; only then is
//   the next transaction taken. Tick: scan all outputs, then walk to emit each expired one
//   (or one empty result); init: one result per output. Rate is set by the single
//   state-table port: one output is read and updated per cycle, unless a result waits.
// Reset (synchronous, rst_n low): all outputs off, owners and deadlines zero, mask zero.
module priority_output_arbiter_top #(
  parameter int NUM_OUTPUTS = poa_pkg::NUM_OUTPUTS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  // request channel
  input  logic               in_valid,
  output logic               in_stall,
  input  poa_pkg::in_item_t  in_data,
  // result channel
  output logic               out_valid,
  input  logic               out_stall,
  output poa_pkg::out_item_t out_data,
  // default-on mask register
  input  logic               cfg_we,
  input  logic [15:0]        cfg_wdata
);
  import poa_pkg::*;

  // Controller <-> datapath handshake: commands one way, status the other.
  poa_cmd_t cmd;
  poa_sts_t sts;

  // The controller holds in_stall high from the accepting edge until the
  // transaction's last result has been loaded into the output register, so
  // only one transaction is ever in flight.
  poa_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  // The datapath owns the per-output state table, the ms-to-s reciprocal
  // multiply (registered before the deadline add), the tick expiry set and
  // the output register that decouples the result side from the walk.
  poa_dp #(
    .NUM_OUTPUTS (NUM_OUTPUTS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .cmd       (cmd),
    .sts       (sts),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

// ----- src/poa_checker.sv -----
// Port-level checker for the arbiter, with its bind to the top level.
`include "priority_output_arbiter_top_macros.svh"

module poa_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_stall,
  input logic               out_valid,
  input logic               out_stall,
  input poa_pkg::out_item_t out_data
);
  import poa_pkg::*;

  `POA_ASSERT_RUN(a_out_hold, out_valid && out_stall |=> out_valid && $stable(out_data), "result changed while stalled")
  `POA_ASSERT_RUN(a_one_in_flight, in_valid && !in_stall |=> in_stall, "second transaction taken while busy")
  `POA_ASSERT_ALL(a_write_target, !(rst_n && out_valid && out_data.drive_valid && (out_data.drive_output == 5'd0)), "pin write without target output")
  `POA_ASSERT_RUN(a_error_last, out_valid && (out_data.status != ST_OK) |-> out_data.last_result, "error result not final")

endmodule

bind priority_output_arbiter_top poa_checker u_poa_checker (.*);

// ----- verif/testbench.sv -----
// Self-checking testbench for priority_output_arbiter_top: directed table, then random phases.
`timescale 1ns / 1ps

module testbench;
  import poa_pkg::*;

  localparam int NOUT = NUM_OUTPUTS_DEF;

  // Operation codes the block must reject
  localparam logic [2:0] OP_BAD_LO = 3'd6;
  localparam logic [2:0] OP_BAD_HI = 3'd7;

  localparam logic [31:0] MS_PER_SEC = 32'd1000;

  // Drain allowance for a tick: the full scan plus the emit walk, with margin
  localparam int DRAIN_CYCLES = 2 * NOUT + 8;
  localparam int LONG_HOLD = 300;
  localparam int PHASES = 6;
  localparam int ITEMS_PER_PHASE = 60;

  typedef struct packed {
    in_item_t  stim;
    logic      typed;
    out_item_t want;
  } dir_row_t;

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_stall;
  in_item_t  in_data;
  logic      out_valid;
  logic      out_stall;
  out_item_t out_data;
  logic      cfg_we;
  logic [15:0] cfg_wdata;

  // Sideband travelling with in_data: a hand-written expectation for this transaction
  logic      row_typed;
  out_item_t row_want;

  // Predictor state, mirrors the block's output table and mask register
  logic [1:0]  out_mode [1:NOUT];
  logic [7:0]  out_prio [1:NOUT];
  logic [15:0] out_rule [1:NOUT];
  logic [31:0] out_deadline [1:NOUT];
  logic [15:0] on_mask;

  out_item_t pending_results[$];
  dir_row_t  dir_rows[$];

  int failures;
  int requests_taken;
  int results_checked;
  int pulses_released;
  int write_faults;

  // Traffic shaping knobs, set by the main sequence
  bit hold_req;
  bit sender_eager;
  bit receiver_eager;
  logic [31:0] sim_seconds;

  priority_output_arbiter_top uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  // 4 ns clock, starts low
  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  // ---------------------------------------------------------------------------
  // Predictor: applies one accepted request to the model state and queues the
  // results it should produce, oldest first.
  // ---------------------------------------------------------------------------
  task automatic apply_request(input in_item_t it);
    out_item_t r;
    logic lvl;
    logic drove;
    logic [1:0] st;
    int k;
    int fired;
    r = '0;
    case (it.operation)
      OP_ON, OP_OFF, OP_TOGGLE, OP_PULSE: begin
        if (it.output_number == 8'd0 || it.output_number > NOUT) begin
          // out-of-range target: flagged, table untouched
          r.status = ST_BAD_OUTPUT;
          r.last_result = 1'b1;
          pending_results.push_back(r);
        end else begin
          k = it.output_number;
          if (it.operation == OP_OFF)
            lvl = 1'b0;
          else if (it.operation == OP_TOGGLE)
            lvl = (out_mode[k] != MODE_ON);
          else
            lvl = 1'b1;
          st = ST_OK;
          drove = 1'b0;
          // lower priority may never switch on; may switch off only as the owner
          if (!(lvl ? (it.request_priority < out_prio[k])
                    : (out_rule[k] != it.owner_id && it.request_priority < out_prio[k])) &&
              !(lvl ? (out_mode[k] == MODE_ON) : (out_mode[k] == MODE_OFF))) begin
            out_mode[k] = lvl ? MODE_ON : MODE_OFF;
            out_prio[k] = it.request_priority;
            out_rule[k] = it.owner_id;
            drove = 1'b1;
            if (!it.write_ok) begin
              out_mode[k] = MODE_FAULT;
              st = ST_WRITE_FAIL;
              write_faults++;
            end
          end
          // pulse arms even when arbitration skipped the drive
          if (it.operation == OP_PULSE && st == ST_OK) begin
            out_mode[k] = MODE_PULSING;
            out_deadline[k] = it.now_time + it.pulse_ms / MS_PER_SEC;
          end
          r.drive_output = drove ? 5'(k) : 5'd0;
          r.drive_level = drove ? lvl : 1'b0;
          r.drive_valid = drove;
          r.result_mode = out_mode[k];
          r.status = st;
          r.last_result = 1'b1;
          pending_results.push_back(r);
        end
      end
      OP_TICK: begin
        fired = 0;
        for (k = 1; k <= NOUT; k++) begin
          if (out_mode[k] == MODE_PULSING && it.now_time >= out_deadline[k]) begin
            out_mode[k] = MODE_OFF;
            out_prio[k] = 8'd0;
            r = '0;
            r.drive_output = 5'(k);
            r.drive_valid = 1'b1;
            r.result_mode = MODE_OFF;
            pending_results.push_back(r);
            fired++;
            pulses_released++;
          end
        end
        if (fired == 0) begin
          r = '0;
          r.last_result = 1'b1;
          pending_results.push_back(r);
        end else begin
          pending_results[pending_results.size() - 1].last_result = 1'b1;
        end
      end
      OP_INIT: begin
        for (k = 1; k <= NOUT; k++) begin
          lvl = on_mask[k-1];
          out_mode[k] = lvl ? MODE_ON : MODE_OFF;
          out_prio[k] = 8'd0;
          out_rule[k] = 16'd0;
          out_deadline[k] = 32'd0;
          r = '0;
          r.drive_output = 5'(k);
          r.drive_level = lvl;
          r.drive_valid = 1'b1;
          r.result_mode = out_mode[k];
          r.last_result = (k == NOUT);
          pending_results.push_back(r);
        end
      end
      default: begin
        r.status = ST_BAD_OP;
        r.last_result = 1'b1;
        pending_results.push_back(r);
      end
    endcase
  endtask

  task automatic compare_field(input string fname, input logic [7:0] want,
                               input logic [7:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", fname, want, got);
      failures++;
    end
  endtask

  // ---------------------------------------------------------------------------
  // Monitor: everything sampled on the rising edge, before the block updates.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    out_item_t want;
    int before_n;
    if (!rst_n) begin
      for (int k = 1; k <= NOUT; k++) begin
        out_mode[k] = MODE_OFF;
        out_prio[k] = 8'd0;
        out_rule[k] = 16'd0;
        out_deadline[k] = 32'd0;
      end
      on_mask = 16'd0;
    end else begin
      if (cfg_we)
        on_mask = cfg_wdata;
      if (out_valid && !out_stall) begin
        if (pending_results.size() == 0) begin
          $error("result with nothing expected: %p", out_data);
          failures++;
        end else begin
          want = pending_results.pop_front();
          compare_field("drive_output", 8'(want.drive_output), 8'(out_data.drive_output));
          compare_field("drive_level", 8'(want.drive_level), 8'(out_data.drive_level));
          compare_field("drive_valid", 8'(want.drive_valid), 8'(out_data.drive_valid));
          compare_field("result_mode", 8'(want.result_mode), 8'(out_data.result_mode));
          compare_field("status", 8'(want.status), 8'(out_data.status));
          compare_field("last_result", 8'(want.last_result), 8'(out_data.last_result));
          results_checked++;
        end
      end
      if (in_valid && !in_stall) begin
        requests_taken++;
        before_n = pending_results.size();
        apply_request(in_data);
        // a typed-in row replaces the predicted single result
        if (row_typed) begin
          while (pending_results.size() > before_n)
            void'(pending_results.pop_back());
          pending_results.push_back(row_want);
        end
      end
    end
  end

  function automatic int draw_gap(input bit eager);
    if (eager || $urandom_range(0, 3) == 0)
      return 0;
    return $urandom_range(0, 16);
  endfunction

  // ---------------------------------------------------------------------------
  // Sender. Called at a falling edge; returns at the falling edge after the
  // transaction has been taken. Valid stays up across back-to-back items.
  // ---------------------------------------------------------------------------
  task automatic offer(input in_item_t it, input logic typed, input out_item_t want);
    int gap;
    gap = draw_gap(sender_eager);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data <= it;
    row_typed <= typed;
    row_want <= want;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
  endtask

  // Drop valid, let every outstanding result through, then let a tick scan
  // finish before touching the mask.
  task automatic quiesce();
    in_valid <= 1'b0;
    while (pending_results.size() != 0)
      @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic write_mask(input logic [15:0] value);
    quiesce();
    cfg_we <= 1'b1;
    cfg_wdata <= value;
    @(negedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  // Well-formed requests on a slowly advancing clock, with some noise mixed in
  function automatic in_item_t random_request();
    in_item_t it;
    int pick;
    it = '0;
    pick = $urandom_range(0, 99);
    if (pick < 70)
      it.operation = 3'($urandom_range(OP_ON, OP_PULSE));
    else if (pick < 84)
      it.operation = OP_TICK;
    else if (pick < 89)
      it.operation = OP_INIT;
    else if (pick < 93)
      it.operation = $urandom_range(0, 1) ? OP_BAD_HI : OP_BAD_LO;
    else
      it.operation = 3'($urandom_range(0, 7));
    if (pick >= 93 || $urandom_range(0, 15) == 0)
      it.output_number = 8'($urandom_range(0, 255));
    else
      it.output_number = 8'($urandom_range(1, NOUT));
    it.request_priority = $urandom_range(0, 3) != 0 ? 8'($urandom_range(0, 4))
                                                     : 8'($urandom_range(0, 255));
    case ($urandom_range(0, 7))
      0, 1, 2, 3: it.owner_id = 16'($urandom_range(0, 3));
      4, 5:       it.owner_id = 16'hFFFF;
      default:    it.owner_id = 16'($urandom_range(0, 65535));
    endcase
    it.pulse_ms = $urandom_range(0, 3) != 0 ? 32'($urandom_range(0, 20000)) : $urandom;
    sim_seconds = sim_seconds + 32'($urandom_range(0, 8));
    it.now_time = $urandom_range(0, 7) != 0 ? sim_seconds : $urandom;
    it.write_ok = ($urandom_range(0, 7) != 0);
    return it;
  endfunction

  function automatic dir_row_t make_row(input logic [2:0] op, input logic [7:0] num,
                                        input logic [7:0] pri, input logic [15:0] id,
                                        input logic [31:0] ms, input logic [31:0] now,
                                        input logic ok, input logic typed,
                                        input out_item_t want);
    dir_row_t row;
    row.stim.operation = op;
    row.stim.output_number = num;
    row.stim.request_priority = pri;
    row.stim.owner_id = id;
    row.stim.pulse_ms = ms;
    row.stim.now_time = now;
    row.stim.write_ok = ok;
    row.typed = typed;
    row.want = want;
    return row;
  endfunction

  // Single, final result with the given fields
  function automatic out_item_t lone(input logic [4:0] num, input logic lvl,
                                     input logic valid, input logic [1:0] mode,
                                     input logic [1:0] st);
    out_item_t r;
    r.drive_output = num;
    r.drive_level = lvl;
    r.drive_valid = valid;
    r.result_mode = mode;
    r.status = st;
    r.last_result = 1'b1;
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Receiver: draws a stall per result; honours a long hold when asked, so the
  // block backs up and stalls its input while the sender keeps offering.
  // ---------------------------------------------------------------------------
  initial begin
    int gap;
    out_stall = 1'b1;
    wait (rst_n === 1'b1);
    forever begin
      @(negedge clk);
      if (hold_req) begin
        out_stall <= 1'b1;
        repeat (LONG_HOLD) @(negedge clk);
        hold_req = 1'b0;
      end else begin
        gap = draw_gap(receiver_eager);
        if (gap > 0) begin
          out_stall <= 1'b1;
          repeat (gap) @(negedge clk);
        end
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!out_valid);
    end
  end

  // Watchdog: far beyond the slowest legal run
  initial begin
    #3_000_000;
    $display("testbench: FAIL");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    row_typed = 1'b0;
    row_want = '0;
    cfg_we = 1'b0;
    cfg_wdata = 16'd0;
    hold_req = 1'b0;
    sender_eager = 1'b0;
    receiver_eager = 1'b0;
    sim_seconds = 32'd1000;
    failures = 0;
    requests_taken = 0;
    results_checked = 0;
    pulses_released = 0;
    write_faults = 0;

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed table. Rows with typed expectations hold from reset onwards;
    // the rest lean on the predictor.
    // bad targets and bad operations
    dir_rows.push_back(make_row(OP_ON, 8'd0, 8'd0, 16'd0, 32'd0, 32'd0, 1'b1, 1'b1,
                                lone(5'd0, 1'b0, 1'b0, MODE_OFF, ST_BAD_OUTPUT)));
    dir_rows.push_back(make_row(OP_PULSE, 8'd17, 8'd9, 16'd3, 32'd5000, 32'd7, 1'b1, 1'b1,
                                lone(5'd0, 1'b0, 1'b0, MODE_OFF, ST_BAD_OUTPUT)));
    dir_rows.push_back(make_row(OP_OFF, 8'hFF, 8'hFF, 16'hFFFF, '1, '1, 1'b0, 1'b1,
                                lone(5'd0, 1'b0, 1'b0, MODE_OFF, ST_BAD_OUTPUT)));
    dir_rows.push_back(make_row(OP_BAD_LO, 8'd1, 8'd0, 16'd0, 32'd0, 32'd0, 1'b1, 1'b1,
                                lone(5'd0, 1'b0, 1'b0, MODE_OFF, ST_BAD_OP)));
    dir_rows.push_back(make_row(OP_BAD_HI, 8'hFF, 8'hFF, 16'hFFFF, '1, '1, 1'b1, 1'b1,
                                lone(5'd0, 1'b0, 1'b0, MODE_OFF, ST_BAD_OP)));
    // tick with nothing pulsing: one empty result
    dir_rows.push_back(make_row(OP_TICK, 8'd0, 8'd0, 16'd0, 32'd0, '1, 1'b1, 1'b1,
                                lone(5'd0, 1'b0, 1'b0, MODE_OFF, ST_OK)));
    // switch on from reset, then a repeat that matches the level
    dir_rows.push_back(make_row(OP_ON, 8'd1, 8'd0, 16'd0, 32'd0, 32'd0, 1'b1, 1'b1,
                                lone(5'd1, 1'b1, 1'b1, MODE_ON, ST_OK)));
    dir_rows.push_back(make_row(OP_ON, 8'd1, 8'd0, 16'd0, 32'd0, 32'd0, 1'b1, 1'b1,
                                lone(5'd0, 1'b0, 1'b0, MODE_ON, ST_OK)));
    // top output, top priority, forced id, pin write fails
    dir_rows.push_back(make_row(OP_ON, 8'd16, 8'hFF, 16'hFFFF, 32'd0, 32'd0, 1'b0, 1'b1,
                                lone(5'd16, 1'b1, 1'b1, MODE_FAULT, ST_WRITE_FAIL)));
    // lower priority, not the owner: cannot switch off
    dir_rows.push_back(make_row(OP_OFF, 8'd16, 8'd0, 16'd1, 32'd0, 32'd0, 1'b1, 1'b1,
                                lone(5'd0, 1'b0, 1'b0, MODE_FAULT, ST_OK)));
    // lower priority but the owner: may switch off
    dir_rows.push_back(make_row(OP_OFF, 8'd16, 8'd0, 16'hFFFF, 32'd0, 32'd0, 1'b1, 1'b1,
                                lone(5'd16, 1'b0, 1'b1, MODE_OFF, ST_OK)));
    // toggle off, then a lower-priority toggle back on that must be skipped
    dir_rows.push_back(make_row(OP_TOGGLE, 8'd1, 8'd10, 16'd5, 32'd0, 32'd0, 1'b1, 1'b0, '0));
    dir_rows.push_back(make_row(OP_TOGGLE, 8'd1, 8'd0, 16'd6, 32'd0, 32'd0, 1'b1, 1'b0, '0));
    // pulses: plain, wrapping deadline, and a skipped request that still re-arms
    dir_rows.push_back(make_row(OP_PULSE, 8'd2, 8'd3, 16'd7, 32'd4999, 32'd100, 1'b1,
                                1'b0, '0));
    dir_rows.push_back(make_row(OP_PULSE, 8'd3, 8'd0, 16'd0, '1, 32'hFFFF_FFF0, 1'b1,
                                1'b0, '0));
    dir_rows.push_back(make_row(OP_PULSE, 8'd2, 8'd1, 16'd8, 32'd10000, 32'd95, 1'b1,
                                1'b0, '0));
    // one short of the deadline, exactly on it, then the far end of time
    dir_rows.push_back(make_row(OP_TICK, 8'd5, 8'd0, 16'd0, 32'd0, 32'd104, 1'b1, 1'b0, '0));
    dir_rows.push_back(make_row(OP_TICK, 8'd0, 8'd0, 16'd0, 32'd0, 32'd105, 1'b0, 1'b0, '0));
    dir_rows.push_back(make_row(OP_TICK, 8'd0, 8'd0, 16'd0, 32'd0, '1, 1'b1, 1'b0, '0));
    // pulse whose write fails stays faulted; toggle from fault drives on
    dir_rows.push_back(make_row(OP_PULSE, 8'd4, 8'd0, 16'd2, 32'd3000, 32'd10, 1'b0,
                                1'b0, '0));
    dir_rows.push_back(make_row(OP_TOGGLE, 8'd4, 8'd0, 16'd0, 32'd0, 32'd0, 1'b1, 1'b0, '0));
    // init with the reset mask
    dir_rows.push_back(make_row(OP_INIT, 8'd9, 8'd0, 16'd0, 32'd0, 32'd0, 1'b0, 1'b0, '0));
    // zero-length pulse expires on a tick at the same second
    dir_rows.push_back(make_row(OP_PULSE, 8'd5, 8'hFF, 16'd0, 32'd0, 32'd0, 1'b1, 1'b0, '0));
    dir_rows.push_back(make_row(OP_TICK, 8'd0, 8'd0, 16'd0, 32'd0, 32'd0, 1'b1, 1'b0, '0));

    foreach (dir_rows[i])
      offer(dir_rows[i].stim, dir_rows[i].typed, dir_rows[i].want);

    // Random phases, each opened by a mask write with the block idle.
    // Phase 1: receiver holds off while the sender pushes flat out.
    // Phase 3: no idling on either side. Phase 4: clock near wrap-around.
    for (int phase = 0; phase < PHASES; phase++) begin
      case (phase)
        0:       write_mask(16'hFFFF);
        1:       write_mask(16'h0000);
        2:       write_mask(16'hA5A5);
        3:       write_mask(16'($urandom));
        4:       write_mask(16'h0001);
        default: write_mask(16'h8000);
      endcase
      sender_eager = (phase == 1) || (phase == 3);
      receiver_eager = (phase == 3);
      if (phase == 1)
        hold_req = 1'b1;
      if (phase == 4)
        sim_seconds = 32'hFFFF_FF00;
      for (int j = 0; j < ITEMS_PER_PHASE; j++)
        offer(random_request(), 1'b0, '0);
    end

    quiesce();

    $display("%0d requests, %0d results checked; %0d pulses released, %0d write faults",
             requests_taken, results_checked, pulses_released, write_faults);
    $display("covered bad targets/ops, ownership and priority skips, pulses, ticks, init");
    if (failures == 0)
      $display("testbench: PASS");
    else
      $display("testbench: FAIL");
    $finish;
  end

endmodule
